@@ sv/jsu_pkg.sv @@
// shared types and codes for the json string unescaper
// job record passed from the front classifier to the back expander
// no dependencies
package jsu_pkg;

  // result kinds as seen on the kind port
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_CTRL      = 3'd0;
  localparam logic [2:0] ERR_ESCAPE    = 3'd1;
  localparam logic [2:0] ERR_HEX       = 3'd2;
  localparam logic [2:0] ERR_SURROGATE = 3'd3;
  localparam logic [2:0] ERR_ZERO      = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd5;

  localparam int unsigned MAX_CAPACITY = 256;
  localparam int unsigned CAP_W        = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_CAPACITY);
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);

  // job queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TEXT,
    PH_ESC,
    PH_HEX_HI,
    PH_WANT_BS,
    PH_WANT_U,
    PH_HEX_LO
  } phase_t;

  typedef enum logic [1:0] {
    JOB_POINT,
    JOB_DONE,
    JOB_ERROR
  } job_kind_t;

  // one classified input: a code point of 1..4 utf-8 bytes, a completion or an error
  typedef struct packed {
    job_kind_t   kind;
    logic [20:0] cp;
    logic [1:0]  nm1;
    logic [7:0]  len;
    logic [2:0]  err;
  } job_t;

endpackage

@@ sv/json_string_unescape_utf8.sv @@
// JSON string unescaper to UTF-8. Bytes of a string body enter through a push/full
// port at up to one per cycle while full is low; the front stage decodes escapes and
// \u sequences and checks capacity in the cycle the byte is taken, and queues at
// most one job per byte (up to four jobs held). The back stage turns each job into
// results, one result per cycle while the output is empty or popped, so a plain
// byte, a completion or an error gives one result and a \u code point one to four.
// With nothing queued ahead, a job passes from the queue entry to the output
// register. The capacity register (cfg_data, 9 bits, reset 256, clamped to 2..256)
// is written on cfg_valid and is to be changed only while no string is in flight.
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       data_byte,
  input  logic             first_of_string,
  input  logic             end_of_data,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic [7:0]       string_length,
  output logic [2:0]       error_code,
  output logic             last_of_run,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  logic accept;
  logic job_valid;
  job_t job;
  logic head_valid;
  job_t head;
  logic head_pop;

  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  jsu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .data_byte       (data_byte),
    .first_of_string (first_of_string),
    .end_of_data     (end_of_data),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .job_valid       (job_valid),
    .job             (job)
  );

  jsu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && job_valid),
    .wr_data  (job),
    .full     (full),
    .rd_en    (head_pop),
    .rd_valid (head_valid),
    .rd_data  (head)
  );

  jsu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .head_pop      (head_pop),
    .empty         (empty),
    .pop           (pop),
    .kind          (kind),
    .out_byte      (out_byte),
    .string_length (string_length),
    .error_code    (error_code),
    .last_of_run   (last_of_run)
  );

endmodule

@@ sv/jsu_front.sv @@
// front part: accepts raw string bytes, tracks the escape state machine,
// checks capacity and classifies each byte into at most one job (uses jsu_pkg)
module jsu_front import jsu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             first_of_string,
  input  logic             end_of_data,
  input  logic             cfg_valid,
  input  logic [CAP_W-1:0] cfg_data,
  output logic             job_valid,
  output job_t             job
);

  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] limit;

  phase_t      phase, phase_next, ph;
  logic [15:0] hex_acc, hex_acc_next, acc;
  logic [1:0]  hex_cnt, hex_cnt_next, cnt;
  logic [9:0]  high_sur, high_sur_next, hs;
  logic [7:0]  out_len, out_len_next, len;

  logic        fail_req;
  logic [2:0]  fail_code;
  logic        emit_req;
  logic        emit_raw;
  logic [20:0] emit_cp;
  logic [1:0]  emit_nm1;
  logic [4:0]  digit;
  logic [15:0] acc_new;
  logic [9:0]  need;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    // bit 4 set marks a valid digit
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") r = {1'b1, 4'(b - 8'h30)};
    else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - 8'h57)};
    else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    if (capacity < CAP_MIN) limit = CAP_MIN;
    else if (capacity > CAP_RESET) limit = CAP_RESET;
    else limit = capacity;
  end

  always_comb begin
    ph  = phase;
    acc = hex_acc;
    cnt = hex_cnt;
    hs  = high_sur;
    len = out_len;
    if (first_of_string) begin
      ph  = PH_TEXT;
      acc = '0;
      cnt = '0;
      hs  = '0;
      len = '0;
    end
    phase_next    = ph;
    hex_acc_next  = acc;
    hex_cnt_next  = cnt;
    high_sur_next = hs;
    out_len_next  = len;

    fail_req  = 1'b0;
    fail_code = ERR_CTRL;
    emit_req  = 1'b0;
    emit_raw  = 1'b0;
    emit_cp   = '0;
    emit_nm1  = '0;
    digit     = hex_digit(data_byte);
    acc_new   = {acc[11:0], digit[3:0]};

    job_valid = 1'b0;
    job       = '{kind: JOB_POINT, cp: '0, nm1: '0, len: '0, err: ERR_CTRL};

    if (ph != PH_IDLE) begin
      if (end_of_data) begin
        fail_req = 1'b1;
      end else begin
        unique case (ph)
          PH_TEXT: begin
            if (data_byte < 8'h20) begin
              fail_req = 1'b1;
            end else if (data_byte == "\"") begin
              job_valid  = 1'b1;
              job.kind   = JOB_DONE;
              job.len    = len;
              phase_next = PH_IDLE;
            end else if (data_byte == "\\") begin
              phase_next = PH_ESC;
            end else begin
              // raw string bytes pass through as they are, one byte each
              emit_req = 1'b1;
              emit_raw = 1'b1;
              emit_cp  = {13'd0, data_byte};
            end
          end
          PH_ESC: begin
            case (data_byte)
              "\"", "\\", "/": begin
                emit_req = 1'b1;
                emit_cp  = {13'd0, data_byte};
              end
              "b": begin emit_req = 1'b1; emit_cp = 21'h08; end
              "f": begin emit_req = 1'b1; emit_cp = 21'h0c; end
              "n": begin emit_req = 1'b1; emit_cp = 21'h0a; end
              "r": begin emit_req = 1'b1; emit_cp = 21'h0d; end
              "t": begin emit_req = 1'b1; emit_cp = 21'h09; end
              "u": begin
                hex_acc_next = '0;
                hex_cnt_next = '0;
                phase_next   = PH_HEX_HI;
              end
              default: begin
                fail_req  = 1'b1;
                fail_code = ERR_ESCAPE;
              end
            endcase
          end
          PH_HEX_HI, PH_HEX_LO: begin
            if (!digit[4]) begin
              fail_req  = 1'b1;
              fail_code = ERR_HEX;
            end else begin
              hex_acc_next = acc_new;
              if (cnt != 2'd3) begin
                hex_cnt_next = cnt + 2'd1;
              end else begin
                hex_cnt_next = '0;
                if (ph == PH_HEX_LO) begin
                  if (acc_new < 16'hdc00 || acc_new > 16'hdfff) begin
                    fail_req  = 1'b1;
                    fail_code = ERR_SURROGATE;
                  end else begin
                    // pair joins to 0x10000 + (high << 10) + low bits
                    emit_req = 1'b1;
                    emit_cp  = 21'h10000 + {1'b0, hs, 10'd0} + {11'd0, acc_new[9:0]};
                  end
                end else if (acc_new >= 16'hd800 && acc_new <= 16'hdbff) begin
                  high_sur_next = acc_new[9:0];
                  phase_next    = PH_WANT_BS;
                end else if (acc_new >= 16'hdc00 && acc_new <= 16'hdfff) begin
                  fail_req  = 1'b1;
                  fail_code = ERR_SURROGATE;
                end else begin
                  emit_req = 1'b1;
                  emit_cp  = {5'd0, acc_new};
                end
              end
            end
          end
          PH_WANT_BS: begin
            if (data_byte == "\\") phase_next = PH_WANT_U;
            else begin
              fail_req  = 1'b1;
              fail_code = ERR_SURROGATE;
            end
          end
          PH_WANT_U: begin
            if (data_byte == "u") begin
              hex_acc_next = '0;
              hex_cnt_next = '0;
              phase_next   = PH_HEX_LO;
            end else begin
              fail_req  = 1'b1;
              fail_code = ERR_SURROGATE;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end

    // utf-8 length of the code point, less one
    if (emit_raw || emit_cp < 21'h80) emit_nm1 = 2'd0;
    else if (emit_cp < 21'h800) emit_nm1 = 2'd1;
    else if (emit_cp < 21'h10000) emit_nm1 = 2'd2;
    else emit_nm1 = 2'd3;
    need = {2'd0, len} + {8'd0, emit_nm1} + 10'd1;

    if (fail_req) begin
      job_valid  = 1'b1;
      job.kind   = JOB_ERROR;
      job.err    = fail_code;
      phase_next = PH_IDLE;
    end else if (emit_req) begin
      job_valid = 1'b1;
      if (need >= {1'b0, limit}) begin
        job.kind   = JOB_ERROR;
        job.err    = ERR_OVERFLOW;
        phase_next = PH_IDLE;
      end else if (emit_cp == '0) begin
        job.kind   = JOB_ERROR;
        job.err    = ERR_ZERO;
        phase_next = PH_IDLE;
      end else begin
        job.kind     = JOB_POINT;
        job.cp       = emit_cp;
        job.nm1      = emit_nm1;
        out_len_next = need[7:0];
        phase_next   = PH_TEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      hex_acc  <= '0;
      hex_cnt  <= '0;
      high_sur <= '0;
      out_len  <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      hex_acc  <= hex_acc_next;
      hex_cnt  <= hex_cnt_next;
      high_sur <= high_sur_next;
      out_len  <= out_len_next;
    end
  end

endmodule

@@ sv/jsu_fifo.sv @@
// short job queue between the front classifier and the back expander
// register array with head read, depth from jsu_pkg
module jsu_fifo import jsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output job_t rd_data
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_wr && !do_rd) count <= count + QCNT_W'(1);
      else if (do_rd && !do_wr) count <= count - QCNT_W'(1);
    end
  end

endmodule

@@ sv/jsu_back.sv @@
// back part: expands each queued job into result transactions, one per
// cycle while the output register is empty or popped (uses jsu_pkg)
module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head,
  output logic       head_pop,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic [7:0] string_length,
  output logic [2:0] error_code,
  output logic       last_of_run
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       last_idx;
  logic [7:0] enc_byte;

  assign empty    = !out_valid;
  assign load     = head_valid && (!out_valid || pop);
  assign last_idx = (head.kind != JOB_POINT) || (idx == head.nm1);
  assign head_pop = load && last_idx;

  // byte idx of the utf-8 form of head.cp
  always_comb begin
    enc_byte = '0;
    case (head.nm1)
      2'd0: enc_byte = head.cp[7:0];
      2'd1: begin
        if (idx == 2'd0) enc_byte = {3'b110, head.cp[10:6]};
        else enc_byte = {2'b10, head.cp[5:0]};
      end
      2'd2: begin
        case (idx)
          2'd0:    enc_byte = {4'b1110, head.cp[15:12]};
          2'd1:    enc_byte = {2'b10, head.cp[11:6]};
          default: enc_byte = {2'b10, head.cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    enc_byte = {5'b11110, head.cp[20:18]};
          2'd1:    enc_byte = {2'b10, head.cp[17:12]};
          2'd2:    enc_byte = {2'b10, head.cp[11:6]};
          default: enc_byte = {2'b10, head.cp[5:0]};
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (load) idx <= last_idx ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_of_run   <= last_idx;
      out_byte      <= '0;
      string_length <= '0;
      error_code    <= ERR_CTRL;
      case (head.kind)
        JOB_POINT: begin
          kind     <= KIND_BYTE;
          out_byte <= enc_byte;
        end
        JOB_DONE: begin
          kind          <= KIND_DONE;
          string_length <= head.len;
        end
        default: begin
          kind       <= KIND_ERROR;
          error_code <= head.err;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_idx_needs_job: assert property (@(posedge clk) disable iff (rst)
    (idx != 2'd0) |-> (head_valid && head.kind == JOB_POINT))
    else $error("byte index set without a multi-byte job at the head");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx <= head.nm1))
    else $error("byte index past the end of the code point");

  a_idx_steps: assert property (@(posedge clk) disable iff (rst)
    (load && !last_idx) |=> (idx == $past(idx) + 2'd1))
    else $error("byte index did not advance");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_BYTE) |-> last_of_run)
    else $error("completion or error not marked last");
`endif

endmodule

@@ tb/json_string_unescape_utf8_tb.sv @@
// self-checking testbench for the json string unescaper: feeds string bodies byte by byte
// through push/full, predicts the utf-8 output stream and checks every popped result
// depends on jsu_pkg and json_string_unescape_utf8
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam int RUN_LIMIT     = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] NO_ERR = 3'd0;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       eod;
  } raw_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] length;
    logic [2:0] err;
    logic       last;
  } decoded_t;

  class unescape_scoreboard;
    logic [CAP_W-1:0] capacity;
    phase_t           scan_phase;
    logic [15:0]      hex_acc;
    logic [1:0]       hex_count;
    logic [9:0]       high_half;
    int               decoded_len;
    decoded_t         step_results[$];
    decoded_t         utf8_expected[$];
    int               mismatch_count;

    function new();
      capacity = CAP_RESET;
      scan_phase = PH_IDLE;
      hex_acc = '0;
      hex_count = '0;
      high_half = '0;
      decoded_len = 0;
      mismatch_count = 0;
    endfunction

    static function int hex_digit_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int usable_capacity();
      int c;
      c = int'(capacity);
      if (c < int'(CAP_MIN)) c = int'(CAP_MIN);
      if (c > int'(MAX_CAPACITY)) c = int'(MAX_CAPACITY);
      return c;
    endfunction

    function void put(logic [1:0] k, logic [7:0] b, logic [7:0] len, logic [2:0] e);
      step_results.push_back('{k, b, len, e, 1'b0});
    endfunction

    function void fail_with(logic [2:0] code);
      scan_phase = PH_IDLE;
      step_results.delete();
      put(KIND_ERROR, '0, '0, code);
    endfunction

    function void append_byte(logic [7:0] b);
      if (decoded_len + 1 >= usable_capacity()) begin
        fail_with(ERR_OVERFLOW);
        return;
      end
      decoded_len++;
      scan_phase = PH_TEXT;
      put(KIND_BYTE, b, '0, NO_ERR);
    endfunction

    function void emit_point(int unsigned p);
      int n;
      n = p < 'h80 ? 1 : p < 'h800 ? 2 : p < 'h10000 ? 3 : 4;
      // a sequence that does not fit is dropped whole, even a zero code point
      if (decoded_len + n >= usable_capacity()) begin
        fail_with(ERR_OVERFLOW);
        return;
      end
      if (p == 0) begin
        fail_with(ERR_ZERO);
        return;
      end
      case (n)
        1: put(KIND_BYTE, 8'(p), '0, NO_ERR);
        2: begin
          put(KIND_BYTE, 8'('hc0 | (p >> 6)), '0, NO_ERR);
          put(KIND_BYTE, 8'('h80 | (p & 'h3f)), '0, NO_ERR);
        end
        3: begin
          put(KIND_BYTE, 8'('he0 | (p >> 12)), '0, NO_ERR);
          put(KIND_BYTE, 8'('h80 | ((p >> 6) & 'h3f)), '0, NO_ERR);
          put(KIND_BYTE, 8'('h80 | (p & 'h3f)), '0, NO_ERR);
        end
        default: begin
          put(KIND_BYTE, 8'('hf0 | (p >> 18)), '0, NO_ERR);
          put(KIND_BYTE, 8'('h80 | ((p >> 12) & 'h3f)), '0, NO_ERR);
          put(KIND_BYTE, 8'('h80 | ((p >> 6) & 'h3f)), '0, NO_ERR);
          put(KIND_BYTE, 8'('h80 | (p & 'h3f)), '0, NO_ERR);
        end
      endcase
      decoded_len += n;
      scan_phase = PH_TEXT;
    endfunction

    function void take_hex(logic [7:0] b, logic low_half);
      int d;
      int unsigned p;
      d = hex_digit_value(b);
      if (d < 0) begin
        fail_with(ERR_HEX);
        return;
      end
      hex_acc = {hex_acc[11:0], 4'(d)};
      if (hex_count != 2'd3) begin
        hex_count++;
        return;
      end
      hex_count = '0;
      if (low_half) begin
        if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
          fail_with(ERR_SURROGATE);
          return;
        end
        p = 32'h10000 + (32'(high_half) << 10) + 32'(hex_acc - 16'hdc00);
        emit_point(p);
      end else if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
        high_half = 10'(hex_acc - 16'hd800);
        scan_phase = PH_WANT_BS;
      end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
        fail_with(ERR_SURROGATE);
      end else begin
        emit_point(32'(hex_acc));
      end
    endfunction

    function void note_accepted_byte(raw_item_t item);
      decoded_t r;
      logic [7:0] b;
      b = item.data;
      step_results.delete();
      if (item.first) begin
        scan_phase = PH_TEXT;
        hex_acc = '0;
        hex_count = '0;
        high_half = '0;
        decoded_len = 0;
      end
      if (scan_phase == PH_IDLE) return;
      if (item.eod) begin
        fail_with(ERR_CTRL);
      end else begin
        case (scan_phase)
          PH_TEXT: begin
            if (b < 8'h20) fail_with(ERR_CTRL);
            else if (b == "\"") begin
              scan_phase = PH_IDLE;
              put(KIND_DONE, '0, 8'(decoded_len), NO_ERR);
            end else if (b == "\\") scan_phase = PH_ESC;
            else append_byte(b);
          end
          PH_ESC: begin
            case (b)
              "\"", "\\", "/": append_byte(b);
              "b": append_byte(8'h08);
              "f": append_byte(8'h0c);
              "n": append_byte(8'h0a);
              "r": append_byte(8'h0d);
              "t": append_byte(8'h09);
              "u": begin
                hex_acc = '0;
                hex_count = '0;
                scan_phase = PH_HEX_HI;
              end
              default: fail_with(ERR_ESCAPE);
            endcase
          end
          PH_HEX_HI: take_hex(b, 1'b0);
          PH_WANT_BS: begin
            if (b == "\\") scan_phase = PH_WANT_U;
            else fail_with(ERR_SURROGATE);
          end
          PH_WANT_U: begin
            if (b == "u") begin
              hex_acc = '0;
              hex_count = '0;
              scan_phase = PH_HEX_LO;
            end else fail_with(ERR_SURROGATE);
          end
          PH_HEX_LO: take_hex(b, 1'b1);
          default: scan_phase = PH_IDLE;
        endcase
      end
      foreach (step_results[i]) begin
        r = step_results[i];
        r.last = (i == step_results.size() - 1);
        utf8_expected.push_back(r);
      end
    endfunction

    function void check_decoded(decoded_t got);
      decoded_t want;
      if (utf8_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind %0d byte %02h length %0d error %0d last %0b",
                   got.kind, got.out_byte, got.length, got.err, got.last);
        return;
      end
      want = utf8_expected.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display({"result mismatch: expected kind %0d byte %02h length %0d error %0d ",
                    "last %0b, got kind %0d byte %02h length %0d error %0d last %0b"},
                   want.kind, want.out_byte, want.length, want.err, want.last,
                   got.kind, got.out_byte, got.length, got.err, got.last);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic [7:0]       data_byte = '0;
  logic             first_of_string = 1'b0;
  logic             end_of_data = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [1:0]       kind;
  logic [7:0]       out_byte;
  logic [7:0]       string_length;
  logic [2:0]       error_code;
  logic             last_of_run;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  unescape_scoreboard sb;
  decoded_t           seen;
  raw_item_t          string_buf[$];
  int                 push_idle_pct = 0;
  int                 pop_idle_pct = 0;
  int                 cycle_count = 0;

  logic [7:0] escape_letters [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};

  // start with end, idle byte, extremes of the byte, bad escape,
  // then a two-byte and a four-byte code point in mixed case and a completion
  raw_item_t directed_items [26] = '{
    '{"x", 1'b1, 1'b1}, '{"x", 1'b0, 1'b0}, '{8'hff, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{"\\", 1'b1, 1'b0}, '{"q", 1'b0, 1'b0},
    '{"\\", 1'b1, 1'b0}, '{"u", 1'b0, 1'b0}, '{"0", 1'b0, 1'b0}, '{"0", 1'b0, 1'b0},
    '{"E", 1'b0, 1'b0}, '{"9", 1'b0, 1'b0},
    '{"\\", 1'b0, 1'b0}, '{"u", 1'b0, 1'b0}, '{"d", 1'b0, 1'b0}, '{"8", 1'b0, 1'b0},
    '{"3", 1'b0, 1'b0}, '{"D", 1'b0, 1'b0},
    '{"\\", 1'b0, 1'b0}, '{"u", 1'b0, 1'b0}, '{"D", 1'b0, 1'b0}, '{"E", 1'b0, 1'b0},
    '{"0", 1'b0, 1'b0}, '{"0", 1'b0, 1'b0}, '{"\"", 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1}
  };

  json_string_unescape_utf8 u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .first_of_string(first_of_string),
    .end_of_data(end_of_data),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .out_byte(out_byte),
    .string_length(string_length),
    .error_code(error_code),
    .last_of_run(last_of_run),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("json_string_unescape_utf8 verification failed");
      $finish;
    end
  end

  // result side: check each popped transaction, then decide pop for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        seen = '{kind, out_byte, string_length, error_code, last_of_run};
        sb.check_decoded(seen);
      end
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  function automatic void add_byte(logic [7:0] b);
    string_buf.push_back('{b, 1'b0, 1'b0});
  endfunction

  function automatic void add_escape_u(logic [15:0] v);
    logic [3:0] nib;
    add_byte("\\");
    add_byte("u");
    for (int i = 3; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) add_byte("0" + 8'(nib));
      else if ($urandom_range(1)) add_byte("A" + 8'(nib) - 8'd10);
      else add_byte("a" + 8'(nib) - 8'd10);
    end
  endfunction

  function automatic void build_string();
    int tokens;
    logic [7:0] b;
    logic [15:0] v;
    raw_item_t head;
    string_buf.delete();
    // now and then a long body to reach the capacity limit
    tokens = ($urandom_range(5) == 0) ? $urandom_range(24, 10) : $urandom_range(8);
    repeat (tokens) begin
      case ($urandom_range(8))
        0, 1, 2, 3: begin
          do b = 8'($urandom_range(255, 32)); while (b == "\"" || b == "\\");
          add_byte(b);
        end
        4, 5: begin
          add_byte("\\");
          add_byte(escape_letters[$urandom_range(7)]);
        end
        6, 7: begin
          case ($urandom_range(2))
            0: v = 16'($urandom_range(16'h7f, 1));
            1: v = 16'($urandom_range(16'h7ff, 16'h80));
            default: begin
              do v = 16'($urandom_range(16'hffff, 16'h800));
              while (v >= 16'hd800 && v <= 16'hdfff);
            end
          endcase
          add_escape_u(v);
        end
        default: begin
          add_escape_u(16'hd800 + 16'($urandom_range(16'h3ff)));
          add_escape_u(16'hdc00 + 16'($urandom_range(16'h3ff)));
        end
      endcase
    end
    case ($urandom_range(16))
      0, 1, 2, 3, 4, 5, 6: add_byte("\"");
      7: add_byte(8'($urandom_range(31)));
      8: string_buf.push_back('{8'($urandom), 1'b0, 1'b1});
      9: begin
        do b = 8'($urandom);
        while (b inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"});
        add_byte("\\");
        add_byte(b);
      end
      10: begin
        add_byte("\\");
        add_byte("u");
        repeat ($urandom_range(3)) add_byte("c");
        do b = 8'($urandom); while (unescape_scoreboard::hex_digit_value(b) >= 0);
        add_byte(b);
      end
      11: begin
        // high surrogate not followed by a backslash-u
        add_escape_u(16'hd800 + 16'($urandom_range(16'h3ff)));
        if ($urandom_range(1)) begin
          do b = 8'($urandom); while (b == "\\");
          add_byte(b);
        end else begin
          add_byte("\\");
          do b = 8'($urandom); while (b == "u");
          add_byte(b);
        end
      end
      12: add_escape_u(16'hdc00 + 16'($urandom_range(16'h3ff)));
      13: begin
        add_escape_u(16'hd800 + 16'($urandom_range(16'h3ff)));
        v = $urandom_range(1) ? 16'($urandom_range(16'hdbff))
                              : 16'($urandom_range(16'hffff, 16'he000));
        add_escape_u(v);
      end
      14: add_escape_u(16'h0000);
      15: begin
        // source runs dry inside an escape
        add_byte("\\");
        if ($urandom_range(1)) begin
          add_byte("u");
          repeat ($urandom_range(3)) add_byte("9");
        end
        string_buf.push_back('{8'($urandom), 1'b0, 1'b1});
      end
      default: ;  // left open, the next start cuts it off
    endcase
    if (string_buf.size() == 0) add_byte("\"");
    head = string_buf.pop_front();
    head.first = 1'b1;
    string_buf.push_front(head);
  endfunction

  task automatic send_item(input raw_item_t item);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= item.data;
    first_of_string <= item.first;
    end_of_data <= item.eod;
    do @(posedge clk); while (full);
    sb.note_accepted_byte(item);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.utf8_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    // an end of data closes whatever string is still open
    send_item(raw_item_t'{8'($urandom), 1'b0, 1'b1});
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_capacity(value);
  endtask

  task automatic run_random_strings(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_string();
      foreach (string_buf[i]) send_item(string_buf[i]);
      sent += string_buf.size();
      // stray bytes, mostly after the string has ended
      repeat ($urandom_range(2))
        send_item(raw_item_t'{8'($urandom), 1'b0, 1'($urandom_range(1))});
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    push_idle_pct <= 17;
    pop_idle_pct <= 60;
    foreach (directed_items[i]) send_item(directed_items[i]);
    run_random_strings(25);
    push_idle_pct <= 60;
    pop_idle_pct <= 17;
    write_capacity('0);
    run_random_strings(8);
    write_capacity(CAP_W'($urandom_range(40, 3)));
    run_random_strings(15);
    push_idle_pct <= 0;
    pop_idle_pct <= 0;
    write_capacity(CAP_MIN);
    run_random_strings(8);
    write_capacity('1);
    run_random_strings(10);
    wait_drained();
    if (sb.mismatch_count == 0 && sb.utf8_expected.size() == 0) begin
      $display("json_string_unescape_utf8 verification clean");
    end else begin
      $display("json_string_unescape_utf8 verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_fifo.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_tb.sv
